// File: sv/node_lifecycle_fsm_core_macros.svh
// assertion macros for the node lifecycle controller
// expects clk_i and rst_ni in the scope of each use
`ifndef NODE_LIFECYCLE_FSM_CORE_MACROS_SVH
`define NODE_LIFECYCLE_FSM_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define NLF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nlf check failed in same cycle");
`define NLF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nlf check failed in next cycle");
`else
`define NLF_ASSERT_SAME(lbl, ante, cons)
`define NLF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: sv/nlf_pkg.sv
// shared types, codes and helpers for the node lifecycle controller
// no dependencies
package nlf_pkg;

  localparam int CountWidth = 16;
  localparam int ChildWidth = 16;
  localparam int CmpWidth   = (CountWidth > ChildWidth) ? CountWidth : ChildWidth;
  localparam int EventWidth = 4;
  localparam int CfgIdxWidth = 1;
  localparam int CfgDataWidth = 2;
  localparam int InDataWidth = 24;
  localparam int OutDataWidth = 16;

  typedef enum logic [4:0] {
    StUninit   = 5'b00001,
    StStarting = 5'b00010,
    StRunning  = 5'b00100,
    StIdling   = 5'b01000,
    StExiting  = 5'b10000
  } life_state_e;

  // event codes
  localparam logic [EventWidth-1:0] EvCreated    = 4'd0;
  localparam logic [EventWidth-1:0] EvCleaned    = 4'd1;
  localparam logic [EventWidth-1:0] EvChildUp    = 4'd2;
  localparam logic [EventWidth-1:0] EvChildDown  = 4'd3;
  localparam logic [EventWidth-1:0] EvParentUp   = 4'd4;
  localparam logic [EventWidth-1:0] EvParentLost = 4'd5;
  localparam logic [EventWidth-1:0] EvQuit       = 4'd6;
  localparam logic [EventWidth-1:0] EvFatal      = 4'd7;
  localparam logic [EventWidth-1:0] EvRecoverOk  = 4'd8;
  localparam logic [EventWidth-1:0] EvRecoverBad = 4'd9;

  localparam logic [1:0] RoleFront = 2'd0;
  localparam logic [1:0] RoleRelay = 2'd1;
  localparam logic [1:0] RoleBack  = 2'd2;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatIllegal = 2'd1;
  localparam logic [1:0] StatNoEvent = 2'd2;

  localparam logic [1:0] ActNone    = 2'd0;
  localparam logic [1:0] ActEnable  = 2'd1;
  localparam logic [1:0] ActDisable = 2'd2;

  localparam logic [CfgIdxWidth-1:0] CfgNodeRole    = 1'd0;
  localparam logic [CfgIdxWidth-1:0] CfgPollingMode = 1'd1;

  localparam logic [2:0] CodeUninit   = 3'd0;
  localparam logic [2:0] CodeStarting = 3'd1;
  localparam logic [2:0] CodeRunning  = 3'd2;
  localparam logic [2:0] CodeIdling   = 3'd3;
  localparam logic [2:0] CodeExiting  = 3'd4;

  typedef struct packed {
    life_state_e             state;
    logic [CountWidth-1:0]   up_count;
    logic [CountWidth-1:0]   down_count;
    logic                    quit_flag;
  } nlf_ctx_t;

  typedef struct packed {
    logic [1:0] status;
    logic       poll_notify;
    logic [1:0] enable_action;
    logic       quit_pending;
    logic [2:0] node_state;
  } nlf_result_t;

  function automatic logic [2:0] state_code(life_state_e st);
    logic [2:0] code;
    case (st)
      StStarting: code = CodeStarting;
      StRunning:  code = CodeRunning;
      StIdling:   code = CodeIdling;
      StExiting:  code = CodeExiting;
      default:    code = CodeUninit;
    endcase
    return code;
  endfunction

  function automatic logic [CountWidth-1:0] sat_inc(logic [CountWidth-1:0] v);
    return (&v) ? v : v + CountWidth'(1);
  endfunction

endpackage

// File: sv/nlf_step.sv
// transition logic for one event: role tables, counters, result fields
// depends on nlf_pkg
module nlf_step (
  input  nlf_pkg::nlf_ctx_t                   ctx_i,
  input  logic [1:0]                          role_i,
  input  logic                                polling_i,
  input  logic [nlf_pkg::EventWidth-1:0]      event_code_i,
  input  logic [nlf_pkg::ChildWidth-1:0]      child_count_i,
  output nlf_pkg::nlf_ctx_t                   ctx_o,
  output nlf_pkg::nlf_result_t                result_o
);

  localparam int CmpW = nlf_pkg::CmpWidth;

  nlf_pkg::life_state_e               st;
  nlf_pkg::life_state_e               st_n;
  nlf_pkg::life_state_e               cmn_st;
  logic [1:0]                         cmn_stat;
  logic [1:0]                         stat;
  logic [nlf_pkg::CountWidth-1:0]     up_inc;
  logic [nlf_pkg::CountWidth-1:0]     down_inc;
  logic [CmpW-1:0]                    kids_x;
  logic [CmpW-1:0]                    up_x;
  logic [CmpW-1:0]                    peak;
  logic                               up_reached;
  logic                               down_reached;
  logic                               notify;

  assign st       = ctx_i.state;
  assign up_inc   = nlf_pkg::sat_inc(ctx_i.up_count);
  assign down_inc = nlf_pkg::sat_inc(ctx_i.down_count);
  assign kids_x   = CmpW'(child_count_i);
  assign up_x     = CmpW'(ctx_i.up_count);
  assign peak     = (up_x > kids_x) ? up_x : kids_x;
  assign up_reached   = CmpW'(up_inc) >= kids_x;
  assign down_reached = CmpW'(down_inc) >= peak;

  // events shared by several roles
  always_comb begin
    cmn_st   = st;
    cmn_stat = nlf_pkg::StatOk;
    case (event_code_i)
      nlf_pkg::EvCleaned: begin
        if (st == nlf_pkg::StExiting) cmn_st = nlf_pkg::StUninit;
        else cmn_stat = nlf_pkg::StatIllegal;
      end
      nlf_pkg::EvParentLost: begin
        cmn_st = (st == nlf_pkg::StRunning) ? nlf_pkg::StIdling : nlf_pkg::StExiting;
      end
      nlf_pkg::EvFatal: cmn_st = nlf_pkg::StExiting;
      nlf_pkg::EvRecoverOk: begin
        if (st == nlf_pkg::StIdling) cmn_st = nlf_pkg::StRunning;
        else cmn_stat = nlf_pkg::StatIllegal;
      end
      nlf_pkg::EvRecoverBad: begin
        if (st == nlf_pkg::StIdling) cmn_st = nlf_pkg::StExiting;
        else if (st != nlf_pkg::StExiting) cmn_stat = nlf_pkg::StatIllegal;
      end
      default: cmn_stat = nlf_pkg::StatNoEvent;
    endcase
  end

  always_comb begin
    st_n             = st;
    stat             = nlf_pkg::StatOk;
    ctx_o.up_count   = ctx_i.up_count;
    ctx_o.down_count = ctx_i.down_count;
    ctx_o.quit_flag  = ctx_i.quit_flag;
    case (role_i)
      nlf_pkg::RoleFront: begin
        case (event_code_i)
          nlf_pkg::EvCreated: begin
            if (st == nlf_pkg::StUninit) st_n = nlf_pkg::StStarting;
            else stat = nlf_pkg::StatIllegal;
          end
          nlf_pkg::EvChildUp: begin
            ctx_o.up_count = up_inc;
            if ((st == nlf_pkg::StStarting && up_reached) || st == nlf_pkg::StIdling) begin
              st_n = nlf_pkg::StRunning;
            end
          end
          nlf_pkg::EvChildDown: begin
            ctx_o.down_count = down_inc;
            if (st == nlf_pkg::StRunning && down_reached) begin
              st_n = ctx_i.quit_flag ? nlf_pkg::StExiting : nlf_pkg::StIdling;
            end
          end
          nlf_pkg::EvQuit: begin
            ctx_o.quit_flag = 1'b1;
            if (st == nlf_pkg::StIdling) st_n = nlf_pkg::StExiting;
          end
          nlf_pkg::EvCleaned, nlf_pkg::EvFatal: begin
            st_n = cmn_st;
            stat = cmn_stat;
          end
          default: stat = nlf_pkg::StatNoEvent;
        endcase
      end
      nlf_pkg::RoleRelay: begin
        case (event_code_i)
          nlf_pkg::EvCreated: begin
            if (st != nlf_pkg::StStarting) stat = nlf_pkg::StatIllegal;
          end
          nlf_pkg::EvChildUp: begin
            ctx_o.up_count = up_inc;
            if (st == nlf_pkg::StStarting && up_reached) st_n = nlf_pkg::StRunning;
          end
          nlf_pkg::EvChildDown: begin
            ctx_o.down_count = down_inc;
            if (st == nlf_pkg::StRunning && down_reached && ctx_i.quit_flag) begin
              st_n = nlf_pkg::StExiting;
            end
          end
          nlf_pkg::EvParentUp: begin
            if (st == nlf_pkg::StUninit) st_n = nlf_pkg::StStarting;
            else stat = nlf_pkg::StatIllegal;
          end
          nlf_pkg::EvQuit: begin
            ctx_o.quit_flag = 1'b1;
            if (child_count_i == '0) st_n = nlf_pkg::StExiting;
          end
          default: begin
            st_n = cmn_st;
            stat = cmn_stat;
          end
        endcase
      end
      nlf_pkg::RoleBack: begin
        case (event_code_i)
          nlf_pkg::EvCreated: begin
            if (st == nlf_pkg::StStarting) st_n = nlf_pkg::StRunning;
            else stat = nlf_pkg::StatIllegal;
          end
          nlf_pkg::EvChildUp, nlf_pkg::EvChildDown: stat = nlf_pkg::StatNoEvent;
          nlf_pkg::EvParentUp: begin
            if (st == nlf_pkg::StUninit) st_n = nlf_pkg::StStarting;
            else stat = nlf_pkg::StatIllegal;
          end
          nlf_pkg::EvQuit: begin
            if (st == nlf_pkg::StRunning) st_n = nlf_pkg::StExiting;
            else if (st != nlf_pkg::StExiting) stat = nlf_pkg::StatIllegal;
          end
          default: begin
            st_n = cmn_st;
            stat = cmn_stat;
          end
        endcase
      end
      default: stat = nlf_pkg::StatNoEvent;
    endcase
    ctx_o.state = st_n;
  end

  // wake the poller: front end going idle or back end exiting
  assign notify = polling_i &&
                  ((role_i == nlf_pkg::RoleFront && st_n == nlf_pkg::StIdling) ||
                   (role_i == nlf_pkg::RoleBack && st_n == nlf_pkg::StExiting));

  always_comb begin
    result_o.node_state   = nlf_pkg::state_code(st_n);
    result_o.quit_pending = ctx_o.quit_flag;
    result_o.poll_notify  = notify;
    result_o.status       = stat;
    if (st_n == nlf_pkg::StExiting) result_o.enable_action = nlf_pkg::ActDisable;
    else if (st_n != nlf_pkg::StUninit) result_o.enable_action = nlf_pkg::ActEnable;
    else result_o.enable_action = nlf_pkg::ActNone;
  end

endmodule

// File: sv/node_lifecycle_fsm_core.sv
// top level of the node lifecycle controller: stream ports, config, state registers
// depends on nlf_pkg, nlf_step and node_lifecycle_fsm_core_macros.svh
//
//   port group  dir  payload
//   s_axis      in   event_code, child_count
//   m_axis      out  node_state, quit_pending, enable_action, poll_notify, status
//   cfg         in   index 0 node_role, index 1 polling_mode
//
// one item per cycle sustained while m_axis is not stalled; an item moves from the input register
// into the result register and leaves from there
// the state update for an item happens as it moves into the result register
// a stalled m_axis holds both registers; s_axis stays ready while the input stage can drain
// reset clears state, counters, quit flag and config; cfg_ready_o is always high
`include "node_lifecycle_fsm_core_macros.svh"

module node_lifecycle_fsm_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // event_code [3:0], child_count [19:4], zero [23:20]
  input  logic [nlf_pkg::InDataWidth-1:0]     s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // node_state [2:0], quit_pending [3], enable_action [5:4], poll_notify [6],
  // status [8:7], zero [15:9]
  output logic [nlf_pkg::OutDataWidth-1:0]    m_axis_tdata_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [nlf_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [nlf_pkg::CfgDataWidth-1:0]    cfg_data_i
);

  localparam int PadW = nlf_pkg::OutDataWidth - $bits(nlf_pkg::nlf_result_t);

  logic                                in_valid_q;
  logic [nlf_pkg::EventWidth-1:0]      event_q;
  logic [nlf_pkg::ChildWidth-1:0]      kids_q;
  logic                                out_valid_q;
  nlf_pkg::nlf_result_t                res_q;
  nlf_pkg::nlf_result_t                res_d;
  nlf_pkg::nlf_ctx_t                   ctx_q;
  nlf_pkg::nlf_ctx_t                   ctx_d;
  logic [1:0]                          role_q;
  logic                                polling_q;
  logic                                out_free;
  logic                                advance;
  logic                                in_load;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign in_load         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q    <= nlf_pkg::RoleFront;
      polling_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        nlf_pkg::CfgNodeRole:    role_q    <= cfg_data_i[1:0];
        nlf_pkg::CfgPollingMode: polling_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      event_q <= s_axis_tdata_i[nlf_pkg::EventWidth-1:0];
      kids_q  <= s_axis_tdata_i[nlf_pkg::EventWidth +: nlf_pkg::ChildWidth];
    end
  end

  nlf_step u_step (
    .ctx_i         (ctx_q),
    .role_i        (role_q),
    .polling_i     (polling_q),
    .event_code_i  (event_q),
    .child_count_i (kids_q),
    .ctx_o         (ctx_d),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.state      <= nlf_pkg::StUninit;
      ctx_q.up_count   <= '0;
      ctx_q.down_count <= '0;
      ctx_q.quit_flag  <= 1'b0;
    end else if (advance) begin
      ctx_q <= ctx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{PadW{1'b0}}, res_q};

  // illegal transition must leave the lifecycle state alone
  `NLF_ASSERT_NEXT(a_illegal_keeps_state, advance && res_d.status == nlf_pkg::StatIllegal, ctx_q.state == $past(ctx_q.state))
  // quit request is sticky
  `NLF_ASSERT_NEXT(a_quit_sticky, ctx_q.quit_flag, ctx_q.quit_flag)
  // saturating counters never go back
  `NLF_ASSERT_NEXT(a_up_monotonic, 1'b1, ctx_q.up_count >= $past(ctx_q.up_count))
  // a result only appears after an item sat in the input register
  `NLF_ASSERT_SAME(a_result_has_source, $rose(out_valid_q), $past(in_valid_q))
  // reported state matches the state register once loaded
  `NLF_ASSERT_NEXT(a_result_tracks_state, advance, res_q.node_state == nlf_pkg::state_code(ctx_q.state))

endmodule
